### design/rce_pkg.sv
`default_nettype none

package rce_pkg;

	// matrix geometry
	localparam int NODES = 16;
	localparam int PIV_W = (NODES > 1) ? $clog2(NODES) : 1;

	// fixed field widths of the stream items
	localparam int OPC_W     = 2;
	localparam int IDX_W     = 4;
	localparam int ROW_OUT_W = 16;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 24;

	typedef enum logic [OPC_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_CLOSE = 2'd2,
		OP_QUERY = 2'd3
	} opcode_t;

	typedef enum logic {
		ST_IDLE,
		ST_CLOSE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic             clear;
		logic             add;
		logic             step;
		logic             load;
		logic             query;
		logic [PIV_W-1:0] pivot;
	} rce_cmd_t;

endpackage

`default_nettype wire

### design/reachability_closure_engine.sv
// Reachability closure engine: a NODES x NODES bit matrix of directed edges.
// Input stream (s_*): one beat is one command - clear the matrix, add edge
// src->dst, close the relation (transitive closure), or query a source row.
// Output stream (m_*): exactly one beat per input beat, in order. Only a
// query returns data (the source row and whether dst is in it); all other
// commands return a zero beat.
// For clear, add and query the result is registered and shows on m_tvalid
// the cycle after the input beat is taken.
// Closure runs Warshall one pivot row per cycle through the single row read
// port, over every pivot row; its zero beat appears after the sweep, and
// s_tready is low throughout.
// A new command is taken in the same cycle that the held result is taken;
// while the receiver stalls, s_tready stays low and the result holds.
// Reset (arst_n low) clears the matrix and the result register and drops
// m_tvalid; no clearing sweep is needed afterwards.
`default_nettype none

module reachability_closure_engine
	import rce_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // opcode[1:0], src_index[5:2], dst_index[9:6]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata   // reachable[0], reach_row[16:1]
);

	rce_cmd_t             cmd;
	logic                 reachable;
	logic [ROW_OUT_W-1:0] reach_row;

	rce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tdata[OPC_W-1:0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rce_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.src_index (s_tdata[OPC_W +: IDX_W]),
		.dst_index (s_tdata[OPC_W + IDX_W +: IDX_W]),
		.reachable (reachable),
		.reach_row (reach_row)
	);

	// pack result beat, pad to whole bytes
	assign m_tdata = {{(M_DATA_W - ROW_OUT_W - 1){1'b0}}, reach_row, reachable};

endmodule

`default_nettype wire

### design/rce_datapath.sv
`default_nettype none

module rce_datapath
	import rce_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  rce_cmd_t                  cmd,
	input  wire logic [IDX_W-1:0]     src_index,
	input  wire logic [IDX_W-1:0]     dst_index,
	output logic                      reachable,
	output logic [ROW_OUT_W-1:0]      reach_row
);

	logic [NODES-1:0] rows_q [NODES];
	logic [PIV_W-1:0] src_sel;
	logic [PIV_W-1:0] dst_sel;
	logic [PIV_W-1:0] rd_addr;
	logic [NODES-1:0] rd_row;
	logic             src_ok;
	logic             dst_ok;
	logic             hit;
	logic             reachable_q;
	logic [ROW_OUT_W-1:0] reach_row_q;

	// index decode and range checks
	assign src_ok  = (32'(src_index) < NODES);
	assign dst_ok  = (32'(dst_index) < NODES);
	assign src_sel = PIV_W'(src_index);
	assign dst_sel = PIV_W'(dst_index);

	// single row read port: pivot row during closure, source row otherwise
	assign rd_addr = cmd.step ? cmd.pivot : src_sel;
	assign rd_row  = rows_q[rd_addr];
	assign hit     = src_ok & dst_ok & rd_row[dst_sel];

	// matrix rows: clear, edge insert, one Warshall pivot step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				rows_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NODES; i++) begin
				if (cmd.clear) begin
					rows_q[i] <= '0;
				end else if (cmd.step) begin
					if (rows_q[i][cmd.pivot]) begin
						rows_q[i] <= rows_q[i] | rd_row;
					end
				end else if (cmd.add && src_ok && dst_ok && src_sel == PIV_W'(i)) begin
					rows_q[i][dst_sel] <= 1'b1;
				end
			end
		end
	end

	// result payload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reachable_q <= 1'b0;
			reach_row_q <= '0;
		end else if (cmd.load) begin
			reachable_q <= cmd.query & hit;
			reach_row_q <= (cmd.query && src_ok) ? ROW_OUT_W'(rd_row) : '0;
		end
	end

	assign reachable = reachable_q;
	assign reach_row = reach_row_q;

endmodule

`default_nettype wire

### design/rce_ctrl.sv
`default_nettype none

module rce_ctrl
	import rce_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [OPC_W-1:0] opcode,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output rce_cmd_t              cmd
);

	state_t           state_q;
	state_t           state_nxt;
	logic [PIV_W-1:0] pivot_q;
	logic             out_valid_q;
	logic             accept;
	logic             last_pivot;
	opcode_t          op;

	assign op         = opcode_t'(opcode);
	assign s_tready   = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept     = s_tvalid && s_tready;
	assign last_pivot = (pivot_q == PIV_W'(NODES - 1));
	assign m_tvalid   = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_CLOSE) begin
					state_nxt = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (last_pivot) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd       = '0;
		cmd.pivot = pivot_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.clear = (op == OP_CLEAR);
					cmd.add   = (op == OP_ADD);
					cmd.query = (op == OP_QUERY);
					cmd.load  = (op != OP_CLOSE);
				end
			end
			ST_CLOSE: begin
				cmd.step = 1'b1;
				cmd.load = last_pivot;
			end
			default: cmd = '0;
		endcase
	end

	// state, pivot counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pivot_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLOSE) begin
				pivot_q <= last_pivot ? '0 : pivot_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// no pending result is overwritten by a new one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || m_tready))
		else $error("result loaded over an unread beat");

	// input is held off for the whole closure sweep
	a_close_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) |-> !s_tready)
		else $error("input ready during closure");

	// closure item starts the sweep at pivot zero
	a_close_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_CLOSE) |=> (state_q == ST_CLOSE && pivot_q == '0))
		else $error("closure sweep did not start at pivot zero");

	// sweep leaves only after the last pivot, with its result
	a_close_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE && !last_pivot) |=> (state_q == ST_CLOSE && !out_valid_q))
		else $error("closure sweep ended early");

endmodule

`default_nettype wire
